// File: rtl/rpn_pkg.sv
// Shared types and constants of the reverse-Polish evaluator.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package rpn_pkg;

  localparam int unsigned VALUE_W  = 32;
  localparam int unsigned MODE_W   = 2;
  localparam int unsigned OPC_W    = 2;
  localparam int unsigned STATUS_W = 3;
  localparam int unsigned DEPTH_W  = 5;

  // Fraction bits of the signed fixed-point format.
  localparam int unsigned FRAC_BITS = 16;

  // Token modes.
  localparam logic [MODE_W-1:0] MODE_PUSH = 2'd0;
  localparam logic [MODE_W-1:0] MODE_OP   = 2'd1;
  localparam logic [MODE_W-1:0] MODE_END  = 2'd2;

  // Operator codes.
  localparam logic [OPC_W-1:0] OP_ADD = 2'd0;
  localparam logic [OPC_W-1:0] OP_SUB = 2'd1;
  localparam logic [OPC_W-1:0] OP_MUL = 2'd2;
  localparam logic [OPC_W-1:0] OP_DIV = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] ST_FEW     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_DIVZERO = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_EXCESS  = 3'd4;
  localparam logic [STATUS_W-1:0] ST_EMPTY   = 3'd5;

  localparam logic signed [VALUE_W-1:0] VAL_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [VALUE_W-1:0] VAL_MIN = 32'sh8000_0000;

  // Token queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QUEUE_AW    = 2;

  // Restoring divider: one quotient bit per step.
  localparam int unsigned DIV_STEPS = 32;
  localparam int unsigned DIV_CNT_W = 5;

  typedef enum logic [1:0] {
    TK_PUSH,
    TK_OP,
    TK_END,
    TK_NOP
  } tok_kind_e;

  typedef struct packed {
    tok_kind_e                  kind;
    logic [OPC_W-1:0]           op;
    logic signed [VALUE_W-1:0]  value;
  } tok_t;

  typedef struct packed {
    logic [STATUS_W-1:0]        status;
    logic signed [VALUE_W-1:0]  result_value;
    logic [DEPTH_W-1:0]         stack_depth;
    logic                       expression_done;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/rpn_if.sv
// Valid/ready channel interfaces of the evaluator: token input and result output.
// Depends on rpn_pkg for the field widths.
`default_nettype none

interface rpn_tok_if import rpn_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [MODE_W-1:0]          mode;
  logic signed [VALUE_W-1:0]  operand_value;
  logic [OPC_W-1:0]           operator_code;

  modport source (output valid, mode, operand_value, operator_code, input ready);
  modport sink   (input valid, mode, operand_value, operator_code, output ready);
endinterface

interface rpn_res_if import rpn_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [STATUS_W-1:0]        status;
  logic signed [VALUE_W-1:0]  result_value;
  logic [DEPTH_W-1:0]         stack_depth;
  logic                       expression_done;

  modport source (output valid, status, result_value, stack_depth, expression_done,
                  input ready);
  modport sink   (input valid, status, result_value, stack_depth, expression_done,
                  output ready);
endinterface

`default_nettype wire

// File: rtl/rpn_front.sv
// Front end: accepts tokens, classifies them and holds them in a short queue.
// Depends on rpn_pkg and rpn_tok_if.
`default_nettype none

module rpn_front import rpn_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpn_tok_if.sink    tok_i,
  output logic       q_valid_o,
  output tok_t       q_tok_o,
  input  logic       q_pop_i
);

  tok_t                in_tok;
  tok_t                fifo_q [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr_q, wr_ptr_d;
  logic [QUEUE_AW-1:0] rd_ptr_q, rd_ptr_d;
  logic [QUEUE_AW:0]   cnt_q, cnt_d;
  logic                push;

  // Classify the token by mode.
  always_comb begin
    in_tok.op    = tok_i.operator_code;
    in_tok.value = tok_i.operand_value;
    case (tok_i.mode)
      MODE_PUSH: in_tok.kind = TK_PUSH;
      MODE_OP:   in_tok.kind = TK_OP;
      MODE_END:  in_tok.kind = TK_END;
      default:   in_tok.kind = TK_NOP;
    endcase
  end

  assign tok_i.ready = (cnt_q != (QUEUE_AW+1)'(QUEUE_DEPTH));
  assign push        = tok_i.valid && tok_i.ready;

  assign wr_ptr_d = push    ? wr_ptr_q + 1'b1 : wr_ptr_q;
  assign rd_ptr_d = q_pop_i ? rd_ptr_q + 1'b1 : rd_ptr_q;

  always_comb begin
    cnt_d = cnt_q;
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      fifo_q[wr_ptr_q] <= in_tok;
    end
  end

  assign q_valid_o = (cnt_q != '0);
  assign q_tok_o   = fifo_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: rtl/rpn_exec.sv
// Back end: operand stack, arithmetic (add/sub, multiply, restoring divider)
// and the result register. Depends on rpn_pkg.
`default_nettype none

module rpn_exec import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  q_valid_i,
  input  tok_t  q_tok_i,
  output logic  q_pop_o,
  output logic  res_valid_o,
  input  logic  res_ready_i,
  output res_t  res_o
);

  localparam int unsigned PW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned IW = $clog2(STACK_DEPTH);
  localparam logic [PW-1:0] SP_FULL = PW'(STACK_DEPTH);
  localparam logic [PW-1:0] SP_TWO  = PW'(2);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_READ   = 3'd1;
  localparam logic [2:0] S_MUL    = 3'd2;
  localparam logic [2:0] S_DIV    = 3'd3;
  localparam logic [2:0] S_DFIN   = 3'd4;
  localparam logic [2:0] S_COMMIT = 3'd5;

  logic [2:0]                state_q, state_d;
  logic [PW-1:0]             sp_q, sp_d;
  logic [STATUS_W-1:0]       err_q, err_d;
  logic                      err_pend_q, err_pend_d;
  logic                      out_valid_q, out_valid_d;
  res_t                      out_q, out_d;

  // Top of stack lives in a register; entries below it live in the memory.
  logic signed [VALUE_W-1:0] tos_q, tos_d;
  logic signed [VALUE_W-1:0] mem [STACK_DEPTH];
  logic signed [VALUE_W-1:0] rd_q;
  logic                      mem_we;

  logic [OPC_W-1:0]          op_q, op_d;
  logic signed [VALUE_W-1:0] res_q, res_d;
  logic signed [63:0]        prod_q, prod_d;
  logic [31:0]               rem_q, rem_d;
  logic [31:0]               quo_q, quo_d;
  logic [31:0]               dvs_q, dvs_d;
  logic                      neg_q, neg_d;
  logic [DIV_CNT_W-1:0]      cnt_q, cnt_d;

  logic                      out_free;
  logic signed [VALUE_W-1:0] top_val;
  logic [PW-1:0]             sp_inc, sp_dec, sp_m2;

  logic signed [63:0]        prod_full;
  logic signed [63:0]        num_s;
  logic [63:0]               num_mag;
  logic [31:0]               d_mag;
  logic                      div_neg, div_ovf;
  logic signed [63:0]        mul_sh;
  logic                      mul_fit;
  logic signed [VALUE_W-1:0] mul_sat;
  logic [32:0]               div_sh, div_sub;
  logic                      div_ge;
  logic signed [VALUE_W-1:0] div_res;

  assign out_free = !out_valid_q || res_ready_i;
  assign top_val  = (sp_q == '0) ? '0 : tos_q;
  assign sp_inc   = sp_q + PW'(1);
  assign sp_dec   = sp_q - PW'(1);
  assign sp_m2    = sp_q - SP_TWO;

  // Left operand comes from the memory, right operand is the top register.
  assign prod_full = rd_q * tos_q;
  assign num_s     = {{32{rd_q[31]}}, rd_q} <<< FRAC_BITS;
  assign num_mag   = num_s[63] ? 64'(-num_s) : 64'(num_s);
  assign d_mag     = tos_q[31] ? 32'(-tos_q) : 32'(tos_q);
  assign div_neg   = rd_q[31] ^ tos_q[31];
  // Quotient would not fit 32 bits: saturate without dividing.
  assign div_ovf   = (num_mag[63:32] >= d_mag);

  // Floor shift, then clamp to the 32-bit range.
  assign mul_sh  = prod_q >>> FRAC_BITS;
  assign mul_fit = (mul_sh[63:31] == '0) || (mul_sh[63:31] == '1);
  assign mul_sat = mul_fit ? mul_sh[31:0] : (mul_sh[63] ? VAL_MIN : VAL_MAX);

  assign div_sh  = {rem_q, quo_q[31]};
  assign div_sub = div_sh - {1'b0, dvs_q};
  assign div_ge  = (div_sh >= {1'b0, dvs_q});

  always_comb begin
    if (neg_q) begin
      div_res = (quo_q > 32'h8000_0000) ? VAL_MIN : 32'(-quo_q);
    end else begin
      div_res = quo_q[31] ? VAL_MAX : quo_q;
    end
  end

  always_comb begin
    state_d    = state_q;
    sp_d       = sp_q;
    err_d      = err_q;
    err_pend_d = err_pend_q;
    tos_d      = tos_q;
    op_d       = op_q;
    res_d      = res_q;
    prod_d     = prod_q;
    rem_d      = rem_q;
    quo_d      = quo_q;
    dvs_d      = dvs_q;
    neg_d      = neg_q;
    cnt_d      = cnt_q;
    out_d      = out_q;
    mem_we     = 1'b0;
    q_pop_o    = 1'b0;
    out_valid_d = (out_valid_q && !res_ready_i);

    case (state_q)
      S_IDLE: begin
        if (q_valid_i && out_free) begin
          q_pop_o                = 1'b1;
          out_valid_d            = 1'b1;
          out_d.expression_done  = 1'b0;
          out_d.status           = err_q;
          out_d.result_value     = top_val;
          out_d.stack_depth      = DEPTH_W'(sp_q);
          case (q_tok_i.kind)
            TK_END: begin
              out_d.expression_done = 1'b1;
              out_d.result_value    = '0;
              out_d.stack_depth     = '0;
              if (err_q != ST_OK) begin
                out_d.status = err_q;
              end else if (sp_q == '0) begin
                out_d.status = ST_EMPTY;
              end else if (sp_q != PW'(1)) begin
                out_d.status = ST_EXCESS;
              end else begin
                out_d.status       = ST_OK;
                out_d.result_value = tos_q;
              end
              sp_d  = '0;
              err_d = ST_OK;
            end
            TK_PUSH: begin
              if (err_q == ST_OK) begin
                if (sp_q == SP_FULL) begin
                  err_d        = ST_FULL;
                  out_d.status = ST_FULL;
                end else begin
                  // Spill the old top into the memory.
                  mem_we             = (sp_q != '0);
                  tos_d              = q_tok_i.value;
                  sp_d               = sp_inc;
                  out_d.result_value = q_tok_i.value;
                  out_d.stack_depth  = DEPTH_W'(sp_inc);
                end
              end
            end
            TK_OP: begin
              if (err_q == ST_OK) begin
                if (sp_q < SP_TWO) begin
                  err_d        = ST_FEW;
                  out_d.status = ST_FEW;
                end else begin
                  // Result comes later; fetch the left operand first.
                  out_valid_d = (out_valid_q && !res_ready_i);
                  out_d       = out_q;
                  op_d        = q_tok_i.op;
                  state_d     = S_READ;
                end
              end
            end
            default: ;
          endcase
        end
      end

      S_READ: begin
        case (op_q)
          OP_ADD: begin
            res_d   = rd_q + tos_q;
            state_d = S_COMMIT;
          end
          OP_SUB: begin
            res_d   = rd_q - tos_q;
            state_d = S_COMMIT;
          end
          OP_MUL: begin
            prod_d  = prod_full;
            state_d = S_MUL;
          end
          OP_DIV: begin
            if (tos_q == '0) begin
              err_pend_d = 1'b1;
              state_d    = S_COMMIT;
            end else if (div_ovf) begin
              res_d   = div_neg ? VAL_MIN : VAL_MAX;
              state_d = S_COMMIT;
            end else begin
              rem_d   = num_mag[63:32];
              quo_d   = num_mag[31:0];
              dvs_d   = d_mag;
              neg_d   = div_neg;
              cnt_d   = '0;
              state_d = S_DIV;
            end
          end
          default: state_d = S_COMMIT;
        endcase
      end

      S_MUL: begin
        res_d   = mul_sat;
        state_d = S_COMMIT;
      end

      S_DIV: begin
        // One quotient bit per cycle.
        rem_d = div_ge ? div_sub[31:0] : div_sh[31:0];
        quo_d = {quo_q[30:0], div_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_d = S_DFIN;
        end
      end

      S_DFIN: begin
        res_d   = div_res;
        state_d = S_COMMIT;
      end

      S_COMMIT: begin
        if (out_free) begin
          out_valid_d           = 1'b1;
          out_d.expression_done = 1'b0;
          state_d               = S_IDLE;
          if (err_pend_q) begin
            err_d              = ST_DIVZERO;
            err_pend_d         = 1'b0;
            out_d.status       = ST_DIVZERO;
            out_d.result_value = tos_q;
            out_d.stack_depth  = DEPTH_W'(sp_q);
          end else begin
            tos_d              = res_q;
            sp_d               = sp_dec;
            out_d.status       = ST_OK;
            out_d.result_value = res_q;
            out_d.stack_depth  = DEPTH_W'(sp_dec);
          end
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      sp_q        <= '0;
      err_q       <= ST_OK;
      err_pend_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      sp_q        <= sp_d;
      err_q       <= err_d;
      err_pend_q  <= err_pend_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    tos_q  <= tos_d;
    op_q   <= op_d;
    res_q  <= res_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    dvs_q  <= dvs_d;
    neg_q  <= neg_d;
    cnt_q  <= cnt_d;
    out_q  <= out_d;
  end

  // Stack memory: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[sp_dec[IW-1:0]] <= tos_q;
    end
    rd_q <= mem[sp_m2[IW-1:0]];
  end

  assign res_valid_o = out_valid_q;
  assign res_o       = out_q;

endmodule

`default_nettype wire

// File: rtl/rpn_stack_evaluator.sv
// Top level of the reverse-Polish evaluator: front queue plus execution back end.
// Depends on rpn_pkg, rpn_tok_if, rpn_res_if, rpn_front and rpn_exec.
//
// Usage:
//   tok_i carries one token per transfer (push number, apply operator, end of
//   expression); res_o returns exactly one result per token, in token order.
//   The front registers accepted tokens into a four-entry queue, so tok_i keeps
//   taking tokens while the back end computes or while a result waits.
//   Back-end steps per token, after the token has passed through the queue:
//     push, end, ignored tokens, too few operands and a full stack: answered
//     in the state that takes the token; add, subtract, divide by zero and a
//     divide that saturates before dividing: operand fetch from the stack
//     memory, compute or check, commit; multiply: one registered 32x32
//     product, then shift and clamp; divide: a restoring divider that yields
//     one quotient bit per cycle over 32 steps.
//   The top of the stack is held in a register; deeper entries sit in a
//   single-port-write, registered-read memory of STACK_DEPTH entries.
//   Reset empties the stack and clears the latched error; the memory contents
//   are not cleared, since only entries below the stack pointer are read.
//   When the receiver holds res_o.ready low the result register holds its
//   transfer, the back end stalls, and tok_i.ready drops once the queue is full.
`default_nettype none

module rpn_stack_evaluator import rpn_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  rpn_tok_if.sink    tok_i,
  rpn_res_if.source  res_o
);

  logic  q_valid;
  logic  q_pop;
  tok_t  q_tok;
  logic  res_valid;
  res_t  res;

  // Accept and classify tokens, buffer them ahead of the back end.
  rpn_front u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .tok_i     (tok_i),
    .q_valid_o (q_valid),
    .q_tok_o   (q_tok),
    .q_pop_i   (q_pop)
  );

  // Evaluate tokens against the stack and register the results.
  rpn_exec #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_exec (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_tok_i     (q_tok),
    .q_pop_o     (q_pop),
    .res_valid_o (res_valid),
    .res_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.valid           = res_valid;
  assign res_o.status          = res.status;
  assign res_o.result_value    = res.result_value;
  assign res_o.stack_depth     = res.stack_depth;
  assign res_o.expression_done = res.expression_done;

endmodule

`default_nettype wire

// File: rtl/rpn_checker.sv
// Port-level assertions for the evaluator, attached to the top level by bind.
// Depends on rpn_pkg and rpn_stack_evaluator.
`default_nettype none

module rpn_checker import rpn_pkg::*; (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       res_valid_i,
  input  logic                       res_ready_i,
  input  logic [STATUS_W-1:0]        status_i,
  input  logic signed [VALUE_W-1:0]  result_value_i,
  input  logic [DEPTH_W-1:0]         stack_depth_i,
  input  logic                       done_i
);

  // Hold a stalled result.
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i && $stable(result_value_i)
      && $stable(status_i) && $stable(done_i))
    else $error("result changed while stalled");

  // End of expression always leaves an empty stack.
  a_end_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_i |-> stack_depth_i == '0)
    else $error("stack not empty after end token");

  // A failed expression reports a zero value.
  a_end_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && done_i && status_i != ST_OK |-> result_value_i == '0)
    else $error("nonzero value on failed expression");

  // Excess and empty codes belong to end tokens only.
  a_mid_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !done_i |-> status_i != ST_EXCESS && status_i != ST_EMPTY)
    else $error("end-only status on a mid-expression result");

endmodule

bind rpn_stack_evaluator rpn_checker u_rpn_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .res_valid_i    (res_o.valid),
  .res_ready_i    (res_o.ready),
  .status_i       (res_o.status),
  .result_value_i (res_o.result_value),
  .stack_depth_i  (res_o.stack_depth),
  .done_i         (res_o.expression_done)
);

`default_nettype wire
